// ===== hw/rtl/cdq_pkg.sv =====
// Package for the circular double-ended queue.
// Holds command and status codes, field widths and the per-word result struct.
// No dependencies.
package cdq_pkg;

  localparam int DataW   = 32;
  localparam int CntW    = 5;
  localparam int CmdW    = 3;
  localparam int CapLimit = 16;
  localparam int InDataW  = 32;
  localparam int OutDataW = 48;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_R = 3'd0,
    CMD_PUSH_L = 3'd1,
    CMD_POP_L  = 3'd2,
    CMD_POP_R  = 3'd3,
    CMD_PEEK_L = 3'd4,
    CMD_PEEK_R = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  // Everything of one result word except the value read from the store.
  typedef struct packed {
    logic            rd_ok;
    status_t         status;
    logic [CntW-1:0] count;
    logic            full;
    logic            empty;
  } meta_t;

endpackage

// ===== hw/rtl/cdq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/cdq_ctrl.sv =====
// Pointer, occupancy and capacity control of the deque.
// Decodes one command per cycle while fire is high and drives the store's write and read ports.
// Depends on cdq_pkg.
module cdq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [cdq_pkg::CntW-1:0]             cfg_wdata,
  input  logic                                 fire,
  input  logic [cdq_pkg::CmdW-1:0]             command,
  input  logic [cdq_pkg::DataW-1:0]            data,
  output logic                                 ram_we,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_waddr,
  output logic [cdq_pkg::DataW-1:0]            ram_wdata,
  output logic                                 ram_re,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_raddr,
  output cdq_pkg::meta_t                       meta
);

  localparam int CntW   = cdq_pkg::CntW;
  localparam int AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CapMax = (DEPTH < cdq_pkg::CapLimit) ? DEPTH : cdq_pkg::CapLimit;
  localparam int PtrW   = (CapMax > 1) ? $clog2(CapMax) : 1;

  logic [CntW-1:0] cap_r, cap_nxt;
  logic [CntW-1:0] occ_r, occ_nxt;
  logic [PtrW-1:0] left_r, left_nxt;
  logic [PtrW-1:0] right_r, right_nxt;

  logic [CntW-1:0] cap_m1;
  logic [PtrW-1:0] home_right;
  logic [PtrW-1:0] left_inc, left_dec, right_inc, right_dec;
  logic            is_full, is_empty;
  logic [CntW-1:0] cfg_cap;
  logic [CntW-1:0] cfg_cap_m1;
  logic            we, re;
  logic [PtrW-1:0] waddr, raddr;
  cdq_pkg::status_t status;

  assign cap_m1     = cap_r - CntW'(1);
  assign home_right = cap_m1[PtrW-1:0];
  assign is_full    = (occ_r >= cap_r);
  assign is_empty   = (occ_r == '0);

  assign left_inc  = (CntW'(left_r) == cap_m1) ? '0 : left_r + PtrW'(1);
  assign left_dec  = (left_r == '0) ? home_right : left_r - PtrW'(1);
  assign right_inc = (CntW'(right_r) == cap_m1) ? '0 : right_r + PtrW'(1);
  assign right_dec = (right_r == '0) ? home_right : right_r - PtrW'(1);

  // Capacity writes of zero become one; large values clamp to the smaller of the store size and CapLimit.
  always_comb begin
    cfg_cap = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_cap = CntW'(1);
    end else if (cfg_wdata > CntW'(CapMax)) begin
      cfg_cap = CntW'(CapMax);
    end
    cfg_cap_m1 = cfg_cap - CntW'(1);
  end

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    occ_nxt   = occ_r;
    status    = cdq_pkg::ST_OK;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = right_inc;
    raddr     = left_r;
    unique case (cdq_pkg::cmd_t'(command))
      cdq_pkg::CMD_PUSH_R: begin
        if (is_full) begin
          status = cdq_pkg::ST_OVER;
        end else begin
          right_nxt = right_inc;
          waddr     = right_inc;
          we        = 1'b1;
          occ_nxt   = occ_r + CntW'(1);
        end
      end
      cdq_pkg::CMD_PUSH_L: begin
        if (is_full) begin
          status = cdq_pkg::ST_OVER;
        end else begin
          left_nxt = left_dec;
          waddr    = left_dec;
          we       = 1'b1;
          occ_nxt  = occ_r + CntW'(1);
        end
      end
      cdq_pkg::CMD_POP_L: begin
        if (is_empty) begin
          status = cdq_pkg::ST_UNDER;
        end else begin
          re      = 1'b1;
          raddr   = left_r;
          occ_nxt = occ_r - CntW'(1);
          // Popping the last entry sends both pointers home.
          if (occ_r == CntW'(1)) begin
            left_nxt  = '0;
            right_nxt = home_right;
          end else begin
            left_nxt = left_inc;
          end
        end
      end
      cdq_pkg::CMD_POP_R: begin
        if (is_empty) begin
          status = cdq_pkg::ST_UNDER;
        end else begin
          re      = 1'b1;
          raddr   = right_r;
          occ_nxt = occ_r - CntW'(1);
          if (occ_r == CntW'(1)) begin
            left_nxt  = '0;
            right_nxt = home_right;
          end else begin
            right_nxt = right_dec;
          end
        end
      end
      cdq_pkg::CMD_PEEK_L: begin
        if (is_empty) begin
          status = cdq_pkg::ST_UNDER;
        end else begin
          re    = 1'b1;
          raddr = left_r;
        end
      end
      cdq_pkg::CMD_PEEK_R: begin
        if (is_empty) begin
          status = cdq_pkg::ST_UNDER;
        end else begin
          re    = 1'b1;
          raddr = right_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign cap_nxt = cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CntW'(CapMax);
      occ_r   <= '0;
      left_r  <= '0;
      right_r <= PtrW'(CapMax - 1);
    end else if (cfg_wr_en) begin
      // The capacity only changes while the deque holds nothing.
      if (is_empty) begin
        cap_r   <= cfg_cap;
        left_r  <= '0;
        right_r <= cfg_cap_m1[PtrW-1:0];
      end
    end else if (fire) begin
      cap_r   <= cap_nxt;
      occ_r   <= occ_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign ram_we    = fire & we;
  assign ram_waddr = AddrW'(waddr);
  assign ram_wdata = data;
  assign ram_re    = fire & re;
  assign ram_raddr = AddrW'(raddr);

  assign meta.rd_ok  = re;
  assign meta.status = status;
  assign meta.count  = occ_nxt;
  assign meta.full   = (occ_nxt == cap_r);
  assign meta.empty  = (occ_nxt == '0);

endmodule

// ===== hw/rtl/circular_double_ended_queue.sv =====
// Top level of the circular double-ended queue: command stream in, one result per command out.
// Depends on cdq_pkg, cdq_ctrl and cdq_ram.
//
//  channel | ports       | contents
//  --------+-------------+------------------------------------------------------
//  in      | in_t*       | tuser: command; tdata: data
//  out     | out_t*      | tdata: value, status, count, full_res, empty_res
//  cfg     | cfg_*       | capacity, taken while the deque is empty
//
// One word is taken every cycle while in_tready is high; its result is registered
// in the stage holding the store's registered read port, then in the output register.
// A stalled output holds the result stage and the stage behind it; in_tready
// drops only when both are occupied.
// Reset is synchronous and clears control state only; the store needs no clearing.
module circular_double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cdq_pkg::InDataW-1:0]   in_tdata,   // [31:0] data
  input  logic [cdq_pkg::CmdW-1:0]      in_tuser,   // [2:0] command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] value, [33:32] status, [38:34] count, [39] full_res, [40] empty_res,
  // [47:41] zero
  output logic [cdq_pkg::OutDataW-1:0]  out_tdata,
  input  logic                          cfg_wr_en,
  input  logic [cdq_pkg::CntW-1:0]      cfg_wdata
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DataW = cdq_pkg::DataW;
  localparam int PadW  = cdq_pkg::OutDataW - DataW - 2 - cdq_pkg::CntW - 2;

  logic             fire;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;
  cdq_pkg::meta_t   meta;

  logic             s1_valid_r, s1_valid_nxt;
  cdq_pkg::meta_t   s1_meta_r;
  logic             s1_move;
  logic             out_valid_r, out_valid_nxt;
  logic [cdq_pkg::OutDataW-1:0] out_data_r;
  logic [DataW-1:0] value;

  assign s1_move   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_move;
  assign fire      = in_tvalid & in_tready;

  cdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .command   (in_tuser),
    .data      (in_tdata[DataW-1:0]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .meta      (meta)
  );

  cdq_ram #(
    .WIDTH(DataW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // The store's read register holds while this stage waits, since reads
  // are issued only for accepted words.
  assign value = s1_meta_r.rd_ok ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_meta_r <= meta;
    end
    if (s1_move) begin
      out_data_r <= {PadW'(0), s1_meta_r.empty, s1_meta_r.full, s1_meta_r.count,
                     s1_meta_r.status, value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== bench/tb_circular_double_ended_queue.sv =====
// Testbench for circular_double_ended_queue: directed and random command streams,
// checked word by word against a scoreboard that tracks the deque contents.
// Depends on cdq_pkg and the circular_double_ended_queue RTL.
module tb_circular_double_ended_queue;

  localparam int Depth = 16;
  localparam int CycleLimit = 200000;
  localparam logic [cdq_pkg::CmdW-1:0] CmdUndefLo = 3'd6;
  localparam logic [cdq_pkg::CmdW-1:0] CmdUndefHi = 3'd7;

  typedef struct {
    logic [cdq_pkg::DataW-1:0] value;
    logic [1:0]                status;
    logic [cdq_pkg::CntW-1:0]  count;
    logic                      full;
    logic                      empty;
  } deque_result_t;

  class deque_scoreboard;
    logic [cdq_pkg::DataW-1:0] mem [Depth];
    int lft, rgt, occ, cap;
    int errors;
    deque_result_t pending_results[$];

    function new();
      cap = Depth;
      occ = 0;
      lft = 0;
      rgt = cap - 1;
      errors = 0;
    endfunction

    // A write only takes effect while the deque is empty.
    function void write_capacity(logic [cdq_pkg::CntW-1:0] v);
      int c;
      c = v;
      if (occ != 0) return;
      if (c < 1) c = 1;
      if (c > cdq_pkg::CapLimit) c = cdq_pkg::CapLimit;
      if (c > Depth) c = Depth;
      cap = c;
      lft = 0;
      rgt = cap - 1;
    endfunction

    function void apply_command(logic [cdq_pkg::CmdW-1:0] cmd,
                                logic [cdq_pkg::DataW-1:0] data);
      deque_result_t r;
      r.value = '0;
      r.status = cdq_pkg::ST_OK;
      lft = lft % cap;
      rgt = rgt % cap;
      case (cmd)
        cdq_pkg::CMD_PUSH_R: begin
          if (occ >= cap) r.status = cdq_pkg::ST_OVER;
          else begin
            rgt = (rgt == cap - 1) ? 0 : rgt + 1;
            mem[rgt] = data;
            occ++;
          end
        end
        cdq_pkg::CMD_PUSH_L: begin
          if (occ >= cap) r.status = cdq_pkg::ST_OVER;
          else begin
            lft = (lft == 0) ? cap - 1 : lft - 1;
            mem[lft] = data;
            occ++;
          end
        end
        cdq_pkg::CMD_POP_L: begin
          if (occ == 0) r.status = cdq_pkg::ST_UNDER;
          else begin
            r.value = mem[lft];
            occ--;
            if (occ == 0) begin
              lft = 0;
              rgt = cap - 1;
            end else lft = (lft == cap - 1) ? 0 : lft + 1;
          end
        end
        cdq_pkg::CMD_POP_R: begin
          if (occ == 0) r.status = cdq_pkg::ST_UNDER;
          else begin
            r.value = mem[rgt];
            occ--;
            if (occ == 0) begin
              lft = 0;
              rgt = cap - 1;
            end else rgt = (rgt == 0) ? cap - 1 : rgt - 1;
          end
        end
        cdq_pkg::CMD_PEEK_L: begin
          if (occ == 0) r.status = cdq_pkg::ST_UNDER;
          else r.value = mem[lft];
        end
        cdq_pkg::CMD_PEEK_R: begin
          if (occ == 0) r.status = cdq_pkg::ST_UNDER;
          else r.value = mem[rgt];
        end
        default: ;
      endcase
      r.count = occ[cdq_pkg::CntW-1:0];
      r.full = (occ == cap);
      r.empty = (occ == 0);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [cdq_pkg::DataW-1:0] exp_v,
                                logic [cdq_pkg::DataW-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [cdq_pkg::OutDataW-1:0] word);
      deque_result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, word);
        errors++;
        return;
      end
      r = pending_results.pop_front();
      compare_field("value", r.value, word[31:0]);
      compare_field("status", r.status, word[33:32]);
      compare_field("count", r.count, word[38:34]);
      compare_field("full_res", r.full, word[39]);
      compare_field("empty_res", r.empty, word[40]);
      compare_field("padding", '0, word[47:41]);
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [cdq_pkg::InDataW-1:0]  in_tdata;
  logic [cdq_pkg::CmdW-1:0]     in_tuser;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [cdq_pkg::OutDataW-1:0] out_tdata;
  logic                         cfg_wr_en;
  logic [cdq_pkg::CntW-1:0]     cfg_wdata;

  deque_scoreboard sb = new();
  bit steady;
  bit hold_req;
  int cycles;

  circular_double_ended_queue #(.DEPTH(Depth)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL circular_double_ended_queue");
      $finish;
    end
  end

  // Result monitor; values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (79) @(negedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 14);
      end
    end
  end

  // Entered and left at a falling edge; in_tvalid stays high on return.
  task automatic send_word(input logic [cdq_pkg::CmdW-1:0] cmd,
                           input logic [cdq_pkg::DataW-1:0] data);
    while (!steady && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    sb.apply_command(cmd, data);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [cdq_pkg::CntW-1:0] v);
    wait_all_results();
    cfg_wr_en <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    sb.write_capacity(v);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [cdq_pkg::DataW-1:0] random_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mode 0 leans toward filling, 1 toward draining, 2 is balanced.
  function automatic logic [cdq_pkg::CmdW-1:0] random_cmd(input int mode);
    int r;
    bit side;
    r = $urandom_range(99);
    side = $urandom_range(1);
    if (r >= 97) return side ? CmdUndefHi : CmdUndefLo;
    case (mode)
      0: r = (r < 65) ? 0 : (r < 80) ? 1 : 2;
      1: r = (r < 20) ? 0 : (r < 35) ? 1 : 2;
      default: r = (r < 40) ? 0 : (r < 60) ? 1 : 2;
    endcase
    case (r)
      0: return side ? cdq_pkg::CMD_PUSH_L : cdq_pkg::CMD_PUSH_R;
      1: return side ? cdq_pkg::CMD_PEEK_L : cdq_pkg::CMD_PEEK_R;
      default: return side ? cdq_pkg::CMD_POP_L : cdq_pkg::CMD_POP_R;
    endcase
  endfunction

  task automatic drain_deque();
    while (sb.occ > 0) begin
      send_word($urandom_range(1) ? cdq_pkg::CMD_POP_L : cdq_pkg::CMD_POP_R, random_word());
    end
  endtask

  initial begin
    logic [cdq_pkg::CntW-1:0] caps [9];
    int mode;
    int burst;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_wr_en = 1'b0;
    cfg_wdata = '0;
    cycles = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    caps = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd7, 5'd16, 5'd0, 5'd31, 5'd17};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty deque at reset capacity: every read reports underflow until the first push.
    send_word(cdq_pkg::CMD_POP_L, 32'h1111_1111);
    send_word(cdq_pkg::CMD_POP_R, 32'h2222_2222);
    send_word(cdq_pkg::CMD_PEEK_L, '0);
    send_word(cdq_pkg::CMD_PEEK_R, '0);
    send_word(CmdUndefLo, '1);
    send_word(CmdUndefHi, '0);
    send_word(cdq_pkg::CMD_PUSH_R, 32'h7FFF_FFFF);
    send_word(cdq_pkg::CMD_PUSH_L, 32'h8000_0000);
    send_word(cdq_pkg::CMD_PEEK_L, '0);
    send_word(cdq_pkg::CMD_PEEK_R, '0);
    send_word(CmdUndefHi, 32'hDEAD_BEEF);
    send_word(cdq_pkg::CMD_POP_R, '0);
    send_word(cdq_pkg::CMD_POP_L, '0);
    // A left push into an empty deque must be visible from the right end.
    send_word(cdq_pkg::CMD_PUSH_L, 32'h1234_5678);
    send_word(cdq_pkg::CMD_POP_R, '0);
    send_word(cdq_pkg::CMD_PUSH_R, 32'hFFFF_FFFF);
    send_word(cdq_pkg::CMD_PUSH_R, 32'h0000_0000);
    send_word(cdq_pkg::CMD_POP_L, '0);
    send_word(cdq_pkg::CMD_POP_L, '0);

    // Capacity one: overflow on both ends, then a write while holding a word.
    write_capacity(5'd1);
    send_word(cdq_pkg::CMD_PUSH_R, 32'hA5A5_A5A5);
    send_word(cdq_pkg::CMD_PUSH_L, 32'h0000_0001);
    send_word(cdq_pkg::CMD_PUSH_R, 32'h5A5A_5A5A);
    send_word(cdq_pkg::CMD_PEEK_R, '0);
    write_capacity(5'd9);
    send_word(cdq_pkg::CMD_PUSH_L, 32'h0F0F_0F0F);
    send_word(cdq_pkg::CMD_POP_L, '0);
    send_word(cdq_pkg::CMD_POP_L, '0);

    for (int p = 0; p < 9; p++) begin
      drain_deque();
      write_capacity(caps[p] == 5'd16 && p == 5 ? 5'($urandom_range(1, 16)) : caps[p]);
      steady = (p == 2);
      mode = 2;
      burst = 0;
      for (int i = 0; i < 80; i++) begin
        if (burst == 0) begin
          mode = $urandom_range(2);
          burst = $urandom_range(8, 40);
        end
        burst--;
        if (p == 4 && i == 10) hold_req = 1'b1;
        if (p == 5 && i == 45) begin
          in_tvalid <= 1'b0;
          while (sb.outstanding() != 0) @(negedge clk);
        end
        send_word(random_cmd(mode), random_word());
      end
      steady = 1'b0;
    end

    wait_all_results();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS circular_double_ended_queue");
    end else begin
      $display("FAIL circular_double_ended_queue");
    end
    $finish;
  end

endmodule

// ===== circular_double_ended_queue.f =====
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/circular_double_ended_queue.sv
bench/tb_circular_double_ended_queue.sv
